@@ src/hsvc_pkg.sv @@
package hsvc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FIELD_W   = 17;

  localparam logic [FIELD_W-1:0] ONE        = FIELD_W'(1 << FRAC_BITS);
  localparam logic [FIELD_W-1:0] DEG_FULL   = FIELD_W'(46080);
  localparam logic [FIELD_W-1:0] DEG_SECTOR = FIELD_W'(7680);
  localparam logic [FIELD_W-1:0] CHAN_MAX   = FIELD_W'(255);

  // floor(rem * 2^FRAC_BITS / 7680) = floor(rem * 128 / 15) = (rem * DEG_RECIP) >> 17
  localparam logic [20:0] DEG_RECIP = 21'd1118482;

  // divider geometry: quotient below 2^17, divisor up to 6 * 255
  localparam int DIV_QW     = 17;
  localparam int DIV_DW     = 11;
  localparam int DIV_RW     = DIV_DW + 1;
  localparam int DIV_NW     = 27;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = 4;

  localparam logic [1:0] CFG_HSV_TO_RGB    = 2'd0;
  localparam logic [1:0] CFG_HUE_IN_DEGREE = 2'd1;

endpackage

@@ src/hsv_rgb_color_converter_core.sv @@
// Pixel converter between HSV and RGB, one pixel per word. Register 0 selects the
// direction (1: hue/saturation/value in, 8-bit red/green/blue out; 0: the reverse),
// register 1 selects the hue scale (0: Q1.16 fraction of a turn, 1: Q9.7 degrees).
// Saturation and value are unsigned Q1.16. Inputs out of range are clamped. The
// block takes one word per clock, unless a stalled word waits at the output,
// through five register stages. The depth is set by one operand stage ahead of
// the four-stage pipelined divider of the RGB to HSV path. A stall on the output
// halts the whole pipeline in place.
// Write configuration only while no word is in flight.
module hsv_rgb_color_converter_core import hsvc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FIELD_W-1:0] first_in,
  input  logic [FIELD_W-1:0] second_in,
  input  logic [FIELD_W-1:0] third_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] first_out,
  output logic [FIELD_W-1:0] second_out,
  output logic [FIELD_W-1:0] third_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic               cfg_data
);

  logic hsv_to_rgb;
  logic hue_in_degrees;
  logic [4:0] vld;
  logic adv;

  assign adv       = !vld[4] || !out_stall;
  assign in_stall  = !adv;
  assign out_valid = vld[4];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hsv_to_rgb     <= 1'b1;
      hue_in_degrees <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HSV_TO_RGB:    hsv_to_rgb     <= cfg_data;
        CFG_HUE_IN_DEGREE: hue_in_degrees <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // stage 1: clamp, hue sector, rgb extremes
  logic [FIELD_W-1:0] hcl, dcl, s_cl, v_cl;
  logic [18:0]        t6;
  logic [2:0]         sec_c;
  logic [FIELD_W-1:0] sec_base;
  logic [7:0]         rc, gc, bc, mx_c, mn_c, d_c;
  logic signed [12:0] diff_c, num_c;
  logic [3:0]         k_c;

  always_comb begin
    hcl  = (first_in > ONE) ? ONE : first_in;
    dcl  = (first_in > DEG_FULL) ? DEG_FULL : first_in;
    s_cl = (second_in > ONE) ? ONE : second_in;
    v_cl = (third_in > ONE) ? ONE : third_in;
    t6   = 19'(hcl) * 19'd6;
    if (dcl >= 17'(6 * 7680))      sec_c = 3'd6;
    else if (dcl >= 17'(5 * 7680)) sec_c = 3'd5;
    else if (dcl >= 17'(4 * 7680)) sec_c = 3'd4;
    else if (dcl >= 17'(3 * 7680)) sec_c = 3'd3;
    else if (dcl >= 17'(2 * 7680)) sec_c = 3'd2;
    else if (dcl >= DEG_SECTOR)    sec_c = 3'd1;
    else                           sec_c = 3'd0;
    sec_base = FIELD_W'(sec_c) * DEG_SECTOR;

    rc = (first_in > CHAN_MAX) ? 8'hff : first_in[7:0];
    gc = (second_in > CHAN_MAX) ? 8'hff : second_in[7:0];
    bc = (third_in > CHAN_MAX) ? 8'hff : third_in[7:0];
    mx_c = rc;
    mn_c = rc;
    if (gc > mx_c) mx_c = gc;
    if (bc > mx_c) mx_c = bc;
    if (gc < mn_c) mn_c = gc;
    if (bc < mn_c) mn_c = bc;
    d_c = mx_c - mn_c;
    if (rc == mn_c) begin
      k_c = 4'd3;
      diff_c = $signed({5'd0, gc}) - $signed({5'd0, bc});
    end else if (bc == mn_c) begin
      k_c = 4'd1;
      diff_c = $signed({5'd0, rc}) - $signed({5'd0, gc});
    end else begin
      k_c = 4'd5;
      diff_c = $signed({5'd0, bc}) - $signed({5'd0, rc});
    end
    num_c = $signed({1'b0, 12'(k_c) * 12'(d_c)}) - diff_c;
  end

  logic [2:0]         sec1_frac, sec1_deg;
  logic [15:0]        f1;
  logic [12:0]        rem1;
  logic [FIELD_W-1:0] s1, v1;
  logic [7:0]         mx1, d1;
  logic [10:0]        num1;
  logic [FIELD_W-1:0] val1;

  always_ff @(posedge clk) begin
    if (adv) begin
      sec1_frac <= t6[18:16];
      sec1_deg  <= sec_c;
      f1        <= t6[15:0];
      rem1      <= 13'(dcl - sec_base);
      s1        <= s_cl;
      v1        <= v_cl;
      mx1       <= mx_c;
      d1        <= d_c;
      num1      <= num_c[12] ? 11'd0 : num_c[10:0];
      // mx * 2^16 / 255 = mx * 257 plus one when mx is 255
      val1      <= FIELD_W'(17'(mx_c) * 17'd257) + FIELD_W'(mx_c == 8'hff);
    end
  end

  // stage 2: fraction within the sector, divider operands
  logic [33:0]        fprod;
  logic [15:0]        f2c;
  logic [2:0]         sec2c;
  logic [FIELD_W-1:0] x_c;
  logic [DIV_NW-1:0]  sn_c, hn_c;
  logic [DIV_DW-1:0]  sd_c, hd_c;

  always_comb begin
    fprod = 34'(rem1) * 34'(DEG_RECIP);
    f2c   = hue_in_degrees ? fprod[32:17] : f1;
    sec2c = hue_in_degrees ? sec1_deg : sec1_frac;
    if (sec2c >= 3'd6) sec2c = 3'd0;
    x_c = sec2c[0] ? FIELD_W'(f2c) : (ONE - FIELD_W'(f2c));
    sn_c = DIV_NW'({d1, 16'd0});
    sd_c = DIV_DW'(mx1);
    if (hue_in_degrees) begin
      hn_c = DIV_NW'(24'(num1) * 24'd7680);
      hd_c = DIV_DW'(d1);
    end else begin
      hn_c = DIV_NW'({num1, 16'd0});
      hd_c = DIV_DW'(11'(d1) * 11'd6);
    end
  end

  logic [2:0]         sec2;
  logic [FIELD_W-1:0] x2, s2, v2, val2;
  logic               grey2;

  always_ff @(posedge clk) begin
    if (adv) begin
      sec2  <= sec2c;
      x2    <= x_c;
      s2    <= s1;
      v2    <= v1;
      val2  <= val1;
      grey2 <= (d1 == 8'd0);
    end
  end

  logic [DIV_QW-1:0] sat_q, hue_q;

  hsvc_div u_sat_div (
    .clk (clk),
    .en  (adv),
    .num (sn_c),
    .den (sd_c),
    .quo (sat_q)
  );

  hsvc_div u_hue_div (
    .clk (clk),
    .en  (adv),
    .num (hn_c),
    .den (hd_c),
    .quo (hue_q)
  );

  // stage 3: v(1-s) and s*x
  logic [33:0] lo_p, sx_p;
  assign lo_p = 34'(v2) * 34'(ONE - s2);
  assign sx_p = 34'(s2) * 34'(x2);

  logic [2:0]         sec3;
  logic [FIELD_W-1:0] v3, lo3, sx3, val3;
  logic               grey3;

  always_ff @(posedge clk) begin
    if (adv) begin
      sec3  <= sec2;
      v3    <= v2;
      lo3   <= lo_p[32:16];
      sx3   <= sx_p[32:16];
      val3  <= val2;
      grey3 <= grey2;
    end
  end

  // stage 4: v(1-s*x)
  logic [33:0] mid_p;
  assign mid_p = 34'(v3) * 34'(ONE - sx3);

  logic [2:0]         sec4;
  logic [FIELD_W-1:0] v4, lo4, mid4, val4;
  logic               grey4;

  always_ff @(posedge clk) begin
    if (adv) begin
      sec4  <= sec3;
      v4    <= v3;
      lo4   <= lo3;
      mid4  <= mid_p[32:16];
      val4  <= val3;
      grey4 <= grey3;
    end
  end

  // stage 5: channel order by sector, scale to 8 bits, lines up with the divider output
  logic [FIELD_W-1:0] pa, pb, pc;
  logic [24:0]        ca, cb, cc;

  always_comb begin
    case (sec4)
      3'd0:    begin pa = v4;   pb = mid4; pc = lo4;  end
      3'd1:    begin pa = mid4; pb = v4;   pc = lo4;  end
      3'd2:    begin pa = lo4;  pb = v4;   pc = mid4; end
      3'd3:    begin pa = lo4;  pb = mid4; pc = v4;   end
      3'd4:    begin pa = mid4; pb = lo4;  pc = v4;   end
      default: begin pa = v4;   pb = lo4;  pc = mid4; end
    endcase
    ca = {pa, 8'd0} - 25'(pa);
    cb = {pb, 8'd0} - 25'(pb);
    cc = {pc, 8'd0} - 25'(pc);
  end

  logic [7:0]         r5, g5, b5;
  logic [FIELD_W-1:0] val5;
  logic               grey5;

  always_ff @(posedge clk) begin
    if (adv) begin
      r5    <= ca[23:16];
      g5    <= cb[23:16];
      b5    <= cc[23:16];
      val5  <= val4;
      grey5 <= grey4;
    end
  end

  always_comb begin
    if (hsv_to_rgb) begin
      first_out  = FIELD_W'(r5);
      second_out = FIELD_W'(g5);
      third_out  = FIELD_W'(b5);
    end else begin
      first_out  = grey5 ? '0 : hue_q;
      second_out = grey5 ? '0 : sat_q;
      third_out  = val5;
    end
  end

endmodule

@@ src/hsvc_div.sv @@
module hsvc_div import hsvc_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic [DIV_QW-1:0] quo
);

  typedef struct packed {
    logic [DIV_RW-1:0] rem;
    logic [DIV_QW-1:0] q;
    logic [DIV_QW-1:0] nlo;
    logic [DIV_DW-1:0] den;
  } div_stage_t;

  localparam int FIRST_STEPS = DIV_QW - (DIV_STAGES - 1) * DIV_STEPS;

  div_stage_t st [DIV_STAGES];
  div_stage_t st_next [DIV_STAGES];

  // restoring division, a few quotient bits per stage
  always_comb begin
    div_stage_t cur;
    logic [DIV_RW-1:0] trial;
    logic qbit;
    for (int j = 0; j < DIV_STAGES; j++) begin
      if (j == 0) begin
        cur.rem = DIV_RW'(num[DIV_NW-1:DIV_QW]);
        cur.q   = '0;
        cur.nlo = num[DIV_QW-1:0];
        cur.den = den;
      end else begin
        cur = st[j-1];
      end
      for (int i = 0; i < FIRST_STEPS; i++) begin
        if ((j == 0) || (i < DIV_STEPS)) begin
          trial = {cur.rem[DIV_RW-2:0], cur.nlo[DIV_QW-1]};
          qbit  = (trial >= {1'b0, cur.den});
          if (qbit) begin
            trial = trial - {1'b0, cur.den};
          end
          cur.rem = trial;
          cur.nlo = {cur.nlo[DIV_QW-2:0], 1'b0};
          cur.q   = {cur.q[DIV_QW-2:0], qbit};
        end
      end
      st_next[j] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < DIV_STAGES; j++) begin
        st[j] <= st_next[j];
      end
    end
  end

  assign quo = st[DIV_STAGES-1].q;

endmodule

@@ dv/hsv_rgb_color_converter_core_tb.sv @@
module hsv_rgb_color_converter_core_tb import hsvc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [FIELD_W-1:0] fld_t;
  typedef struct packed {
    fld_t a;
    fld_t b;
    fld_t c;
  } pixel_t;
  typedef struct {
    pixel_t px;
    bit     known;
    pixel_t want;
  } row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  fld_t first_in, second_in, third_in;
  logic out_valid;
  logic out_stall;
  fld_t first_out, second_out, third_out;
  logic cfg_valid;
  logic cfg_ready;
  logic [1:0] cfg_index;
  logic cfg_data;

  hsv_rgb_color_converter_core dut (.*);

  localparam int LIMIT = 2000;

  bit mode_hsv_to_rgb;
  bit mode_degrees;
  pixel_t expected_pixels[$];
  int errors;
  int idle_cycles;
  bit out_idle_enable;
  bit in_idle_enable;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned clip(longint unsigned a, longint unsigned hi);
    return a > hi ? hi : a;
  endfunction

  function automatic pixel_t convert_pixel(pixel_t p);
    longint unsigned one, sector, f, x, s, v, lo, mid, d, t, ch[3];
    longint signed r, g, b, mx, mn, dl, diff, k, num;
    pixel_t res;
    one = 64'd1 << FRAC_BITS;
    if (mode_hsv_to_rgb) begin
      if (mode_degrees) begin
        d = clip(p.a, 46080);
        sector = d / 7680;
        f = ((d % 7680) << FRAC_BITS) / 7680;
      end else begin
        t = 6 * clip(p.a, one);
        sector = t >> FRAC_BITS;
        f = t & (one - 1);
      end
      if (sector >= 6) sector = 0;
      x = sector[0] ? f : one - f;
      s = clip(p.b, one);
      v = clip(p.c, one);
      lo = (v * (one - s)) >> FRAC_BITS;
      mid = (v * (one - ((s * x) >> FRAC_BITS))) >> FRAC_BITS;
      case (sector)
        0: begin ch[0] = v; ch[1] = mid; ch[2] = lo; end
        1: begin ch[0] = mid; ch[1] = v; ch[2] = lo; end
        2: begin ch[0] = lo; ch[1] = v; ch[2] = mid; end
        3: begin ch[0] = lo; ch[1] = mid; ch[2] = v; end
        4: begin ch[0] = mid; ch[1] = lo; ch[2] = v; end
        default: begin ch[0] = v; ch[1] = lo; ch[2] = mid; end
      endcase
      res.a = fld_t'(clip((255 * ch[0]) >> FRAC_BITS, 'h1ffff));
      res.b = fld_t'(clip((255 * ch[1]) >> FRAC_BITS, 'h1ffff));
      res.c = fld_t'(clip((255 * ch[2]) >> FRAC_BITS, 'h1ffff));
    end else begin
      r = clip(p.a, 255);
      g = clip(p.b, 255);
      b = clip(p.c, 255);
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      res.c = fld_t'(clip((mx << FRAC_BITS) / 255, 'h1ffff));
      dl = mx - mn;
      if (dl == 0) begin
        res.a = '0;
        res.b = '0;
      end else begin
        res.b = fld_t'(clip((dl << FRAC_BITS) / mx, 'h1ffff));
        if (r == mn) begin
          k = 3; diff = g - b;
        end else if (b == mn) begin
          k = 1; diff = r - g;
        end else begin
          k = 5; diff = b - r;
        end
        num = k * dl - diff;
        if (num < 0) num = 0;
        if (mode_degrees) res.a = fld_t'(clip((num * 7680) / dl, 'h1ffff));
        else res.a = fld_t'(clip((num << FRAC_BITS) / (6 * dl), 'h1ffff));
      end
    end
    return res;
  endfunction

  // output side: random stall, compare each accepted word
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= out_idle_enable && ($urandom_range(99) < 34);
    end
  end

  always @(posedge clk) begin
    pixel_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{first_out, second_out, third_out};
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected word %h %h %h", $time, got.a, got.b, got.c);
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        if (got.a !== want.a) begin
          $display("%0t: first_out expected %h actual %h", $time, want.a, got.a);
          errors++;
        end
        if (got.b !== want.b) begin
          $display("%0t: second_out expected %h actual %h", $time, want.b, got.b);
          errors++;
        end
        if (got.c !== want.c) begin
          $display("%0t: third_out expected %h actual %h", $time, want.c, got.c);
          errors++;
        end
      end
    end
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, bit val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_HSV_TO_RGB) mode_hsv_to_rgb = val;
    else if (idx == CFG_HUE_IN_DEGREE) mode_degrees = val;
  endtask

  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // drive one word, holding valid across back-to-back words
  task automatic send_pixel(pixel_t p, bit known, pixel_t want);
    if (in_idle_enable && ($urandom_range(99) < 34)) begin
      in_valid <= 1'b0;
      first_in <= fld_t'($urandom);
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    first_in <= p.a;
    second_in <= p.b;
    third_in <= p.c;
    do @(posedge clk); while (in_stall);
    if (known) expected_pixels.push_back(want);
    else expected_pixels.push_back(convert_pixel(p));
    @(negedge clk);
  endtask

  function automatic fld_t rand_field(bit rgb);
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return fld_t'($urandom);
    if (rgb) return fld_t'($urandom_range(255));
    if (mode_degrees && mode_hsv_to_rgb) return fld_t'($urandom_range(46080));
    return fld_t'($urandom_range(65536));
  endfunction

  task automatic run_random(int count);
    pixel_t p;
    for (int i = 0; i < count; i++) begin
      p.a = rand_field(!mode_hsv_to_rgb);
      p.b = mode_hsv_to_rgb ? fld_t'($urandom_range(65536)) : rand_field(1'b1);
      p.c = mode_hsv_to_rgb ? fld_t'($urandom_range(65536)) : rand_field(1'b1);
      if ($urandom_range(19) == 0) p.b = fld_t'($urandom);
      if ($urandom_range(19) == 0) p.c = fld_t'($urandom);
      if (!mode_hsv_to_rgb && $urandom_range(9) == 0) p.b = p.a;
      if (!mode_hsv_to_rgb && $urandom_range(14) == 0) p.c = p.a;
      send_pixel(p, 1'b0, '0);
    end
  endtask

  row_t hsv_rows[$];
  row_t rgb_rows[$];

  initial begin
    row_t row;
    errors = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    first_in = '0;
    second_in = '0;
    third_in = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = 1'b0;
    out_idle_enable = 1'b1;
    in_idle_enable = 1'b1;
    mode_hsv_to_rgb = 1'b1;
    mode_degrees = 1'b0;

    // hsv rows: black, white, pure red, hue and field clamps, sector edges
    hsv_rows = '{
      '{'{17'd0, 17'd0, 17'd0}, 1'b1, '{17'd0, 17'd0, 17'd0}},
      '{'{17'd0, 17'd0, 17'h10000}, 1'b1, '{17'd255, 17'd255, 17'd255}},
      '{'{17'd0, 17'h10000, 17'h10000}, 1'b1, '{17'd255, 17'd0, 17'd0}},
      '{'{17'h1ffff, 17'h1ffff, 17'h1ffff}, 1'b1, '{17'd255, 17'd0, 17'd0}},
      '{'{17'h10000, 17'h10000, 17'h10000}, 1'b1, '{17'd255, 17'd0, 17'd0}},
      '{'{17'd10922, 17'h10000, 17'h10000}, 1'b0, '0},
      '{'{17'd10923, 17'h8000, 17'h10000}, 1'b0, '0},
      '{'{17'd21846, 17'h10000, 17'h8000}, 1'b0, '0},
      '{'{17'h8000, 17'h10000, 17'h10000}, 1'b0, '0},
      '{'{17'd43691, 17'h4000, 17'hc000}, 1'b0, '0},
      '{'{17'd54613, 17'h10000, 17'h10000}, 1'b0, '0},
      '{'{17'hffff, 17'hffff, 17'hffff}, 1'b0, '0}
    };
    rgb_rows = '{
      '{'{17'd0, 17'd0, 17'd0}, 1'b1, '{17'd0, 17'd0, 17'd0}},
      '{'{17'd255, 17'd255, 17'd255}, 1'b1, '{17'd0, 17'd0, 17'h10000}},
      '{'{17'h1ffff, 17'h1ffff, 17'h1ffff}, 1'b1, '{17'd0, 17'd0, 17'h10000}},
      '{'{17'd255, 17'd0, 17'd0}, 1'b1, '{17'd0, 17'h10000, 17'h10000}},
      '{'{17'd0, 17'd255, 17'd0}, 1'b0, '0},
      '{'{17'd0, 17'd0, 17'd255}, 1'b0, '0},
      '{'{17'd255, 17'd0, 17'd1}, 1'b0, '0},
      '{'{17'd255, 17'd255, 17'd0}, 1'b0, '0},
      '{'{17'd1, 17'd0, 17'd0}, 1'b0, '0},
      '{'{17'd100, 17'd300, 17'd50}, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset defaults: hsv to rgb, fraction hue
    foreach (hsv_rows[i]) send_pixel(hsv_rows[i].px, hsv_rows[i].known, hsv_rows[i].want);
    drain_pipeline();
    write_reg(CFG_HUE_IN_DEGREE, 1'b1);
    row = '{'{17'd46080, 17'h10000, 17'h10000}, 1'b1, '{17'd255, 17'd0, 17'd0}};
    send_pixel(row.px, row.known, row.want);
    send_pixel('{17'h1ffff, 17'h8000, 17'h10000}, 1'b0, '0);
    send_pixel('{17'd15360, 17'h10000, 17'h10000}, 1'b0, '0);
    send_pixel('{17'd46079, 17'h10000, 17'h10000}, 1'b0, '0);
    run_random(120);
    drain_pipeline();

    write_reg(CFG_HSV_TO_RGB, 1'b0);
    foreach (rgb_rows[i]) send_pixel(rgb_rows[i].px, rgb_rows[i].known, rgb_rows[i].want);
    run_random(150);
    drain_pipeline();

    write_reg(CFG_HUE_IN_DEGREE, 1'b0);
    foreach (rgb_rows[i]) send_pixel(rgb_rows[i].px, 1'b0, '0);
    // long stretch with no idling on either side
    out_idle_enable = 1'b0;
    in_idle_enable = 1'b0;
    run_random(150);
    out_idle_enable = 1'b1;
    in_idle_enable = 1'b1;
    // sender holds off until the pipeline is empty
    in_valid <= 1'b0;
    drain_pipeline();

    write_reg(CFG_HSV_TO_RGB, 1'b1);
    run_random(150);
    drain_pipeline();
    write_reg(CFG_HUE_IN_DEGREE, 1'b1);
    run_random(150);
    in_valid <= 1'b0;

    fork
      begin
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
      end
      begin
        repeat (LIMIT) @(negedge clk);
      end
    join_any
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
